[hdl/i2cmra_pkg.sv]
package i2cmra_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd5000;
  localparam logic [7:0] READ_BIT = 8'h01;
  localparam logic [7:0] MSB_MASK = 8'h80;

  typedef struct packed {
    logic       op;
    logic       is_read;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [15:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_sample;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       write_taken;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic       failed;
  } out_t;

endpackage

[hdl/i2c_master_register_access_unit.sv]
// I2C master for register writes and register reads, advanced one bus phase
// per input transfer.
// Input channel (in_valid/in_ready, in_data): op=1 while idle starts a
//   transaction (kind, device byte, register byte, length); op=0 is a phase
//   tick that carries the sampled SDA level and the next write data byte.
//   A begin seen while a transaction runs is treated as a plain tick.
// Result channel (out_valid/out_ready, out_data): exactly one result per
//   input transfer with the SCL/SDA drive for that phase, write_taken,
//   read data, busy, done and failed.
// Config channel (cfg_valid/cfg_ready, cfg_data): ACK timeout in ticks, always
//   ready; write it only while the block is idle. A value of 0 acts as 1.
// Timing: one transfer per cycle while out_ready stays high. The next state and
//   the result are computed in one pass from the phase registers and the incoming
//   transfer and land in the result register, visible the cycle after acceptance.
// Stall: in_ready is high while the result register is empty or being drained,
//   so a stalled receiver holds the result and back-pressures the input.
// Reset (rst_n low, synchronous): phase idle, counters and held bytes cleared,
//   timeout back to 5000, result register empty.
module i2c_master_register_access_unit #(
  parameter int unsigned COUNT_WIDTH = i2cmra_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2cmra_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output i2cmra_pkg::out_t  out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_START    = 5'd1,
    PH_SEND_DEV = 5'd2,
    PH_SEND_REG = 5'd3,
    PH_SEND_DAT = 5'd4,
    PH_SEND_RDV = 5'd5,
    PH_ACK_DEV  = 5'd6,
    PH_ACK_REG  = 5'd7,
    PH_ACK_DAT  = 5'd8,
    PH_ACK_RDV  = 5'd9,
    PH_RS_A     = 5'd10,
    PH_RS_B     = 5'd11,
    PH_RS_C     = 5'd12,
    PH_READ     = 5'd13,
    PH_MACK     = 5'd14,
    PH_STOP_A   = 5'd15,
    PH_STOP_B   = 5'd16,
    PH_STOP_C   = 5'd17,
    PH_FSTOP_A  = 5'd18,
    PH_FSTOP_B  = 5'd19,
    PH_FSTOP_C  = 5'd20
  } phase_t;

  // phase and transaction state
  phase_t                 phase_r, phase_nxt;
  logic [3:0]             bit_cnt_r, bit_cnt_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [COUNT_WIDTH-1:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]             dev_r, dev_nxt;
  logic [7:0]             reg_r, reg_nxt;
  logic                   read_mode_r, read_mode_nxt;
  logic [15:0]            ack_wait_r, ack_wait_nxt;
  logic [15:0]            ack_timeout_r;

  // result register
  logic                   out_valid_r;
  i2cmra_pkg::out_t       out_data_r, res_nxt;

  logic                   in_fire;
  logic [15:0]            limit;
  logic [16:0]            wait_inc;
  logic [COUNT_WIDTH-1:0] bl_dec;
  logic                   scl, sdl, drv, wt, rv, busy, done, fail;
  logic [7:0]             rb;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign limit    = (ack_timeout_r == 16'd0) ? 16'd1 : ack_timeout_r;
  assign wait_inc = {1'b0, ack_wait_r} + 17'd1;
  assign bl_dec   = bytes_left_r - COUNT_WIDTH'(1);

  always_comb begin
    phase_nxt      = phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    dev_nxt        = dev_r;
    reg_nxt        = reg_r;
    read_mode_nxt  = read_mode_r;
    ack_wait_nxt   = ack_wait_r;
    scl  = 1'b1;
    sdl  = 1'b0;
    drv  = 1'b1;
    wt   = 1'b0;
    rb   = 8'h00;
    rv   = 1'b0;
    busy = 1'b1;
    done = 1'b0;
    fail = 1'b0;

    case (phase_r)
      PH_START: begin
        sdl         = 1'b0;
        shift_nxt   = dev_r;
        bit_cnt_nxt = 4'd0;
        phase_nxt   = PH_SEND_DEV;
      end
      PH_SEND_DEV, PH_SEND_REG, PH_SEND_DAT, PH_SEND_RDV: begin
        scl = bit_cnt_r[0];
        sdl = |(shift_r & i2cmra_pkg::MSB_MASK);
        if (bit_cnt_r[0]) begin
          shift_nxt = {shift_r[6:0], 1'b0};
        end
        if (bit_cnt_r == 4'd15) begin
          bit_cnt_nxt = 4'd0;
          case (phase_r)
            PH_SEND_DEV: phase_nxt = PH_ACK_DEV;
            PH_SEND_REG: phase_nxt = PH_ACK_REG;
            PH_SEND_DAT: phase_nxt = PH_ACK_DAT;
            default:     phase_nxt = PH_ACK_RDV;
          endcase
        end else begin
          bit_cnt_nxt = bit_cnt_r + 4'd1;
        end
      end
      PH_ACK_DEV, PH_ACK_REG, PH_ACK_DAT, PH_ACK_RDV: begin
        drv = 1'b0;
        if (!bit_cnt_r[0]) begin
          // SCL low half of the ACK bit, arm the poll counter
          scl          = 1'b0;
          bit_cnt_nxt  = 4'd1;
          ack_wait_nxt = 16'd0;
        end else if (in_data.sda_sample) begin
          // no ACK yet: keep polling until timeout
          if (wait_inc >= {1'b0, limit}) begin
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_FSTOP_A;
          end else begin
            ack_wait_nxt = wait_inc[15:0];
          end
        end else begin
          bit_cnt_nxt = 4'd0;
          case (phase_r)
            PH_ACK_DEV: begin
              shift_nxt = reg_r;
              phase_nxt = PH_SEND_REG;
            end
            PH_ACK_REG: begin
              if (read_mode_r) begin
                phase_nxt = PH_RS_A;
              end else if (bytes_left_r == '0) begin
                phase_nxt = PH_STOP_A;
              end else begin
                shift_nxt = in_data.write_byte;
                wt        = 1'b1;
                phase_nxt = PH_SEND_DAT;
              end
            end
            PH_ACK_DAT: begin
              bytes_left_nxt = bl_dec;
              if (bl_dec == '0) begin
                phase_nxt = PH_STOP_A;
              end else begin
                shift_nxt = in_data.write_byte;
                wt        = 1'b1;
                phase_nxt = PH_SEND_DAT;
              end
            end
            default: begin
              phase_nxt = (bytes_left_r == '0) ? PH_STOP_A : PH_READ;
            end
          endcase
        end
      end
      PH_RS_A: begin
        scl       = 1'b0;
        sdl       = 1'b1;
        phase_nxt = PH_RS_B;
      end
      PH_RS_B: begin
        sdl       = 1'b1;
        phase_nxt = PH_RS_C;
      end
      PH_RS_C: begin
        sdl         = 1'b0;
        shift_nxt   = dev_r | i2cmra_pkg::READ_BIT;
        bit_cnt_nxt = 4'd0;
        phase_nxt   = PH_SEND_RDV;
      end
      PH_READ: begin
        drv = 1'b0;
        scl = bit_cnt_r[0];
        if (bit_cnt_r[0]) begin
          shift_nxt = {shift_r[6:0], in_data.sda_sample};
        end
        if (bit_cnt_r == 4'd15) begin
          bit_cnt_nxt = 4'd0;
          phase_nxt   = PH_MACK;
        end else begin
          bit_cnt_nxt = bit_cnt_r + 4'd1;
        end
      end
      PH_MACK: begin
        // ACK for every byte but the last, which gets NACK
        sdl = (bytes_left_r > COUNT_WIDTH'(1)) ? 1'b0 : 1'b1;
        if (!bit_cnt_r[0]) begin
          scl         = 1'b0;
          rb          = shift_r;
          rv          = 1'b1;
          bit_cnt_nxt = 4'd1;
        end else begin
          bit_cnt_nxt    = 4'd0;
          bytes_left_nxt = bl_dec;
          phase_nxt      = (bl_dec == '0) ? PH_STOP_A : PH_READ;
        end
      end
      PH_STOP_A: begin
        scl       = 1'b0;
        phase_nxt = PH_STOP_B;
      end
      PH_FSTOP_A: begin
        scl       = 1'b0;
        phase_nxt = PH_FSTOP_B;
      end
      PH_STOP_B: begin
        phase_nxt = PH_STOP_C;
      end
      PH_FSTOP_B: begin
        phase_nxt = PH_FSTOP_C;
      end
      PH_STOP_C, PH_FSTOP_C: begin
        sdl       = 1'b1;
        busy      = 1'b0;
        done      = 1'b1;
        fail      = (phase_r == PH_FSTOP_C);
        phase_nxt = PH_IDLE;
      end
      default: begin
        // idle, and any stray code
        phase_nxt = PH_IDLE;
        sdl       = 1'b1;
        if (in_data.op) begin
          dev_nxt        = in_data.device_address;
          reg_nxt        = in_data.register_address;
          bytes_left_nxt = in_data.byte_count[COUNT_WIDTH-1:0];
          read_mode_nxt  = in_data.is_read;
          bit_cnt_nxt    = 4'd0;
          shift_nxt      = 8'h00;
          ack_wait_nxt   = 16'd0;
          phase_nxt      = PH_START;
        end else begin
          busy = 1'b0;
        end
      end
    endcase

    res_nxt.scl_level   = scl;
    res_nxt.sda_level   = drv & sdl;
    res_nxt.sda_drive   = drv;
    res_nxt.write_taken = wt;
    res_nxt.read_byte   = rb;
    res_nxt.read_valid  = rv;
    res_nxt.busy_res    = busy;
    res_nxt.done_res    = done;
    res_nxt.failed      = fail;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bit_cnt_r     <= 4'd0;
      shift_r       <= 8'h00;
      bytes_left_r  <= '0;
      dev_r         <= 8'h00;
      reg_r         <= 8'h00;
      read_mode_r   <= 1'b0;
      ack_wait_r    <= 16'd0;
      ack_timeout_r <= i2cmra_pkg::ACK_TIMEOUT_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ack_timeout_r <= cfg_data;
      end
      if (in_fire) begin
        phase_r      <= phase_nxt;
        bit_cnt_r    <= bit_cnt_nxt;
        shift_r      <= shift_nxt;
        bytes_left_r <= bytes_left_nxt;
        dev_r        <= dev_nxt;
        reg_r        <= reg_nxt;
        read_mode_r  <= read_mode_nxt;
        ack_wait_r   <= ack_wait_nxt;
        out_data_r   <= res_nxt;
      end
      out_valid_r <= in_fire || (out_valid_r && !out_ready);
    end
  end

endmodule

[hdl/i2cmra_checker.sv]
module i2cmra_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input i2cmra_pkg::out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a finished transaction is no longer busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res && out_data.scl_level)
    else $error("done with busy or SCL low");

  a_fail_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.failed |-> out_data.done_res)
    else $error("failed without done");

  // read data appears on the master ACK set-up phase only
  a_read_mack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_valid |-> out_data.sda_drive && !out_data.scl_level
      && out_data.busy_res)
    else $error("read byte outside master ACK");

  // data byte is latched at a slave ACK, with SDA released
  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_taken |-> !out_data.sda_drive && out_data.busy_res
      && !out_data.read_valid)
    else $error("write byte taken outside slave ACK");

endmodule

bind i2c_master_register_access_unit i2cmra_checker u_i2cmra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[verif/tb_i2c_master_register_access_unit.sv]
module tb_i2c_master_register_access_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Bus phase codes, one per step of the transaction sequencer.
  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_START    = 5'd1,
    PH_SEND_DEV = 5'd2,
    PH_SEND_REG = 5'd3,
    PH_SEND_DAT = 5'd4,
    PH_SEND_RDV = 5'd5,
    PH_ACK_DEV  = 5'd6,
    PH_ACK_REG  = 5'd7,
    PH_ACK_DAT  = 5'd8,
    PH_ACK_RDV  = 5'd9,
    PH_RS_A     = 5'd10,
    PH_RS_B     = 5'd11,
    PH_RS_C     = 5'd12,
    PH_READ     = 5'd13,
    PH_MACK     = 5'd14,
    PH_STOP_A   = 5'd15,
    PH_STOP_B   = 5'd16,
    PH_STOP_C   = 5'd17,
    PH_FSTOP_A  = 5'd18,
    PH_FSTOP_B  = 5'd19,
    PH_FSTOP_C  = 5'd20
  } phase_t;

  // Input op codes and transaction kinds.
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_BEGIN   = 1'b1;
  localparam logic XFER_WRITE = 1'b0;
  localparam logic XFER_READ  = 1'b1;

  // ACK index meaning "never force a NACK".
  localparam int NO_ABORT = -1;

  // Tracks the bus sequencer and holds the bus phases still to be seen on
  // the result channel.
  class bus_phase_scoreboard;
    phase_t               phase;
    logic [3:0]           bit_count;
    logic [7:0]           shifter;
    logic [15:0]          bytes_left;
    logic [7:0]           dev_byte;
    logic [7:0]           reg_byte;
    logic                 read_mode;
    logic [15:0]          ack_polls;
    logic [15:0]          ack_timeout;
    i2cmra_pkg::out_t     expected_phases[$];
    int unsigned          fail_count;

    function new();
      phase       = PH_IDLE;
      bit_count   = '0;
      shifter     = '0;
      bytes_left  = '0;
      dev_byte    = '0;
      reg_byte    = '0;
      read_mode   = 1'b0;
      ack_polls   = '0;
      ack_timeout = i2cmra_pkg::ACK_TIMEOUT_RESET;
      fail_count  = 0;
    endfunction

    function int unsigned pending();
      return expected_phases.size();
    endfunction

    function bit polling_ack();
      return phase inside {PH_ACK_DEV, PH_ACK_REG, PH_ACK_DAT, PH_ACK_RDV};
    endfunction

    // Advance one bus phase for an accepted input transfer.
    function void note_tick(i2cmra_pkg::in_t t);
      i2cmra_pkg::out_t r;
      logic             sdl;
      logic [15:0]      limit;

      r             = '0;
      r.scl_level   = 1'b1;
      r.sda_drive   = 1'b1;
      r.busy_res    = 1'b1;
      sdl           = 1'b0;
      limit         = (ack_timeout == 16'd0) ? 16'd1 : ack_timeout;

      case (phase)
        PH_START: begin
          sdl       = 1'b0;
          shifter   = dev_byte;
          bit_count = '0;
          phase     = PH_SEND_DEV;
        end
        PH_SEND_DEV, PH_SEND_REG, PH_SEND_DAT, PH_SEND_RDV: begin
          r.scl_level = bit_count[0];
          sdl         = shifter[7];
          if (bit_count[0]) shifter = shifter << 1;
          if (bit_count == 4'd15) begin
            bit_count = '0;
            case (phase)
              PH_SEND_DEV: phase = PH_ACK_DEV;
              PH_SEND_REG: phase = PH_ACK_REG;
              PH_SEND_DAT: phase = PH_ACK_DAT;
              default:     phase = PH_ACK_RDV;
            endcase
          end else begin
            bit_count++;
          end
        end
        PH_ACK_DEV, PH_ACK_REG, PH_ACK_DAT, PH_ACK_RDV: begin
          r.sda_drive = 1'b0;
          if (!bit_count[0]) begin
            r.scl_level = 1'b0;
            bit_count   = 4'd1;
            ack_polls   = '0;
          end else if (t.sda_sample) begin
            if ({1'b0, ack_polls} + 17'd1 >= {1'b0, limit}) begin
              bit_count = '0;
              phase     = PH_FSTOP_A;
            end else begin
              ack_polls++;
            end
          end else begin
            bit_count = '0;
            if (phase == PH_ACK_DEV) begin
              shifter = reg_byte;
              phase   = PH_SEND_REG;
            end else if (phase == PH_ACK_RDV) begin
              phase = (bytes_left == 16'd0) ? PH_STOP_A : PH_READ;
            end else if (phase == PH_ACK_REG && read_mode) begin
              phase = PH_RS_A;
            end else begin
              if (phase == PH_ACK_DAT) bytes_left--;
              if (bytes_left == 16'd0) begin
                phase = PH_STOP_A;
              end else begin
                shifter       = t.write_byte;
                r.write_taken = 1'b1;
                phase         = PH_SEND_DAT;
              end
            end
          end
        end
        PH_RS_A: begin
          r.scl_level = 1'b0;
          sdl         = 1'b1;
          phase       = PH_RS_B;
        end
        PH_RS_B: begin
          sdl   = 1'b1;
          phase = PH_RS_C;
        end
        PH_RS_C: begin
          sdl       = 1'b0;
          shifter   = dev_byte | i2cmra_pkg::READ_BIT;
          bit_count = '0;
          phase     = PH_SEND_RDV;
        end
        PH_READ: begin
          r.sda_drive = 1'b0;
          r.scl_level = bit_count[0];
          if (bit_count[0]) shifter = {shifter[6:0], t.sda_sample};
          if (bit_count == 4'd15) begin
            bit_count = '0;
            phase     = PH_MACK;
          end else begin
            bit_count++;
          end
        end
        PH_MACK: begin
          sdl = (bytes_left > 16'd1) ? 1'b0 : 1'b1;
          if (!bit_count[0]) begin
            r.scl_level  = 1'b0;
            r.read_byte  = shifter;
            r.read_valid = 1'b1;
            bit_count    = 4'd1;
          end else begin
            bit_count = '0;
            bytes_left--;
            phase = (bytes_left == 16'd0) ? PH_STOP_A : PH_READ;
          end
        end
        PH_STOP_A, PH_FSTOP_A: begin
          r.scl_level = 1'b0;
          sdl         = 1'b0;
          phase       = (phase == PH_STOP_A) ? PH_STOP_B : PH_FSTOP_B;
        end
        PH_STOP_B, PH_FSTOP_B: begin
          sdl   = 1'b0;
          phase = (phase == PH_STOP_B) ? PH_STOP_C : PH_FSTOP_C;
        end
        PH_STOP_C, PH_FSTOP_C: begin
          sdl        = 1'b1;
          r.busy_res = 1'b0;
          r.done_res = 1'b1;
          r.failed   = (phase == PH_FSTOP_C);
          phase      = PH_IDLE;
        end
        default: begin
          sdl   = 1'b1;
          phase = PH_IDLE;
          if (t.op == OP_BEGIN) begin
            dev_byte   = t.device_address;
            reg_byte   = t.register_address;
            bytes_left = t.byte_count;
            read_mode  = t.is_read;
            bit_count  = '0;
            shifter    = '0;
            ack_polls  = '0;
            phase      = PH_START;
          end else begin
            r.busy_res = 1'b0;
          end
        end
      endcase

      r.sda_level = r.sda_drive ? sdl : 1'b0;
      expected_phases.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_phase(i2cmra_pkg::out_t got);
      i2cmra_pkg::out_t want;
      if (expected_phases.size() == 0) begin
        $error("result transfer with no bus phase pending: 0x%0h", got);
        fail_count++;
        return;
      end
      want = expected_phases.pop_front();
      compare_field("scl_level", want.scl_level, got.scl_level);
      compare_field("sda_level", want.sda_level, got.sda_level);
      compare_field("sda_drive", want.sda_drive, got.sda_drive);
      compare_field("write_taken", want.write_taken, got.write_taken);
      compare_field("read_byte", want.read_byte, got.read_byte);
      compare_field("read_valid", want.read_valid, got.read_valid);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("done_res", want.done_res, got.done_res);
      compare_field("failed", want.failed, got.failed);
    endfunction
  endclass

  // All block inputs start at known values; reset is held from time zero.
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  i2cmra_pkg::in_t  in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  i2cmra_pkg::out_t out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [15:0]      cfg_data  = '0;

  bus_phase_scoreboard sb = new();

  // Idling knobs, percent per cycle; changed only between phases.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // Forced NACK timeouts only where the timeout is short enough to afford.
  bit          aborts_allowed = 1'b1;
  int unsigned ticks_sent     = 0;

  i2c_master_register_access_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Result side: random back-pressure, one decision per cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Results are sampled at the edge, i.e. the values the block saw there.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_phase(out_data);
  end

  function automatic i2cmra_pkg::in_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(i2cmra_pkg::in_t)-1:0];
  endfunction

  // One input transfer. The bus phase is predicted at the accepting edge,
  // before the next item is built, so the generator always sees fresh state.
  task automatic push_tick(input i2cmra_pkg::in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(item);
    ticks_sent++;
  endtask

  // Hold the sender off until every pending bus phase has come back.
  // Always waits on a clock edge first so valid is never lowered and raised
  // in the same step.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Timeout register write, only with the block idle and drained.
  task automatic write_timeout(input logic [15:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.ack_timeout = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One full transaction: begin transfer, then ticks until the sequencer is
  // back to idle. SDA answers during ACK polls follow nack_pct; at ACK
  // number abort_ack (0 device, 1 register, then data or read-device) SDA
  // is held high until the timeout fires. Other tick fields stay random, and
  // busy_op_pct of the ticks carry a begin that must act as a plain tick.
  task automatic run_transfer(input logic rd, input logic [7:0] dev,
                              input logic [7:0] reg_byte, input logic [15:0] count,
                              input int abort_ack, input int unsigned nack_pct,
                              input int unsigned busy_op_pct);
    i2cmra_pkg::in_t item;
    int              ack_idx;
    item                  = random_item();
    item.op               = OP_BEGIN;
    item.is_read          = rd;
    item.device_address   = dev;
    item.register_address = reg_byte;
    item.byte_count       = count;
    push_tick(item);
    ack_idx = -1;
    do begin
      item    = random_item();
      item.op = ($urandom_range(99) < busy_op_pct) ? OP_BEGIN : OP_TICK;
      if (sb.polling_ack()) begin
        // even bit count: SCL-low set-up of a fresh ACK slot
        if (!sb.bit_count[0]) ack_idx++;
        item.sda_sample = (ack_idx == abort_ack) ? 1'b1 : ($urandom_range(99) < nack_pct);
      end
      push_tick(item);
      // occasional mid-transaction pause with everything drained
      if ($urandom_range(199) == 0) drain_results();
    end while (sb.phase != PH_IDLE);
  endtask

  task automatic random_transfer();
    logic        rd;
    logic [15:0] count;
    int          abort_ack;
    int unsigned pick;
    int unsigned nack_pct;
    rd   = ($urandom_range(1) == 0) ? XFER_WRITE : XFER_READ;
    pick = $urandom_range(99);
    // mostly short; a long count only when a NACK can cut it off
    if (pick < 80) count = 16'($urandom_range(3));
    else if (pick < 95 || !aborts_allowed) count = 16'($urandom_range(4, 8));
    else count = 16'($urandom);
    abort_ack = NO_ABORT;
    if (aborts_allowed && (count > 16'd8 || $urandom_range(99) < 15)) begin
      abort_ack = (rd == XFER_READ) ? $urandom_range(2)
                                    : $urandom_range(((count > 16'd3) ? 3 : count) + 1);
    end
    nack_pct = ($urandom_range(1) == 0) ? 0 : $urandom_range(10, 40);
    run_transfer(rd, 8'($urandom), 8'($urandom), count, abort_ack, nack_pct, 5);
  endtask

  // One random phase: new timeout and idling mode, transactions with idle
  // noise ticks between them until the item budget is used.
  task automatic random_phase(input logic [15:0] timeout, input int unsigned send_pct,
                              input int unsigned recv_pct, input int unsigned budget);
    int unsigned     first;
    i2cmra_pkg::in_t item;
    write_timeout(timeout);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    aborts_allowed = (timeout <= 16'd64);
    first          = ticks_sent;
    while (ticks_sent - first < budget) begin
      random_transfer();
      repeat ($urandom_range(3)) begin
        item    = random_item();
        item.op = OP_TICK;
        push_tick(item);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset timeout, no idling.
    // zero-length write and read: straight to STOP after the address ACKs
    run_transfer(XFER_WRITE, 8'h00, 8'h00, 16'd0, NO_ABORT, 0, 0);
    run_transfer(XFER_READ, 8'hFE, 8'hFF, 16'd0, NO_ABORT, 0, 0);
    // write with delayed ACKs, then a read where every tick is a begin
    run_transfer(XFER_WRITE, 8'hA5, 8'h5A, 16'd2, NO_ABORT, 30, 0);
    run_transfer(XFER_READ, 8'h42, 8'h81, 16'd3, NO_ABORT, 0, 100);
    // single-byte read: the only byte gets NACK
    run_transfer(XFER_READ, 8'hFF, 8'h00, 16'd1, NO_ABORT, 0, 0);
    // short timeout on a data ACK of a maximal write
    write_timeout(16'd24);
    run_transfer(XFER_WRITE, 8'h3C, 8'hC3, 16'hFFFF, 3, 0, 0);
    // timeout 0 acts as a single poll
    write_timeout(16'd0);
    run_transfer(XFER_READ, 8'h7E, 8'hE7, 16'hFFFF, 2, 0, 0);
    run_transfer(XFER_WRITE, 8'h10, 8'h01, 16'h8000, 0, 0, 0);
    run_transfer(XFER_WRITE, 8'h80, 8'h7F, 16'd1, NO_ABORT, 0, 0);

    // Random part: no idling, sender idle, receiver stalls, both.
    random_phase(16'hFFFF, 0, 0, 100);
    random_phase(16'd1, 86, 0, 100);
    random_phase(16'd3, 0, 86, 100);
    random_phase(16'($urandom_range(2, 40)), 13, 13, 100);
    random_phase(16'($urandom_range(4, 16)), 0, 0, 100);

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) $error("%0d bus phases never came back", sb.pending());
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("i2c_master_register_access_unit test passed");
    end else begin
      $display("i2c_master_register_access_unit test failed");
    end
    $finish;
  end

  // Hang guard: well over ten times the slowest legal run.
  initial begin
    #1ms;
    $display("i2c_master_register_access_unit test failed");
    $finish;
  end

endmodule
